FILE: src/fbm_pkg.sv
// Shared register codes, constants and hash/blend functions for the
// fractal value noise unit. Used by every module of the block; no dependencies.
package fbm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LACUN   = 2'd2;

  localparam logic [3:0]  OCTAVES_RST = 4'd4;
  localparam logic [15:0] GAIN_RST    = 16'd32768;
  localparam logic [14:0] LACUN_RST   = 15'd8192;

  localparam int FREQ_W = 49;
  localparam int AMP_W  = 17;
  localparam int VAL_W  = 23;
  localparam int WGT_W  = 17;

  localparam logic [FREQ_W-1:0] FREQ_ONE = 49'd4096;
  localparam logic [FREQ_W-1:0] FREQ_CAP = 49'd1 << 48;
  localparam logic [AMP_W-1:0]  AMP_ONE  = 17'h10000;

  localparam logic [31:0] HASH_SALT = 32'd61;
  localparam logic [31:0] WANG_K    = 32'h27d4eb2d;

  localparam logic [63:0] OFS_X    = 64'd29059816;
  localparam logic [63:0] OFS_Y    = 64'd37515533;
  localparam logic [63:0] OFS_Z    = 64'd52705624;
  localparam int          OFS_FRAC = 24;

  function automatic logic [31:0] wang_pre(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = (v ^ HASH_SALT) ^ (v >> 16);
    b = (a << 3) + a;
    return b ^ (b >> 4);
  endfunction

  function automatic logic [31:0] wang_mul(input logic [31:0] c);
    return c * WANG_K;
  endfunction

  function automatic logic [31:0] wang_post(input logic [31:0] d);
    return d ^ (d >> 15);
  endfunction

  function automatic logic [VAL_W-1:0] value_mix(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [WGT_W-1:0] w);
    logic [WGT_W-1:0] wi;
    logic [40:0]      s;
    wi = AMP_ONE - w;
    s  = 41'(a) * 41'(wi) + 41'(b) * 41'(w);
    return s[38:16];
  endfunction

endpackage

FILE: src/fbm_octave_cell.sv
// One octave of the noise sum: scale, offset, corner hashing, quintic fade and
// trilinear blend, accumulation when active, next frequency and amplitude. Depends on fbm_pkg.
module fbm_octave_cell #(
  parameter int IDX  = 0,
  parameter int FRAC = 16,
  parameter int SUMW = 43,
  parameter int TOTW = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        active_i,
  input  logic [15:0]                 gain_i,
  input  logic [14:0]                 lacun_i,
  input  logic                        valid_i,
  input  logic [31:0]                 mag_i [3],
  input  logic [2:0]                  neg_i,
  input  logic [fbm_pkg::FREQ_W-1:0]  freq_i,
  input  logic [fbm_pkg::AMP_W-1:0]   amp_i,
  input  logic [SUMW-1:0]             sum_i,
  input  logic [TOTW-1:0]             tot_i,
  output logic                        valid_o,
  output logic [31:0]                 mag_o [3],
  output logic [2:0]                  neg_o,
  output logic [fbm_pkg::FREQ_W-1:0]  freq_o,
  output logic [fbm_pkg::AMP_W-1:0]   amp_o,
  output logic [SUMW-1:0]             sum_o,
  output logic [TOTW-1:0]             tot_o
);

  localparam int SW  = FRAC + 32;
  localparam int LAT = 13;
  localparam int VW  = fbm_pkg::VAL_W;
  localparam int WW  = fbm_pkg::WGT_W;

  function automatic logic [SW-1:0] axis_ofs(input int a);
    logic [63:0] c;
    case (a)
      0:       c = fbm_pkg::OFS_X;
      1:       c = fbm_pkg::OFS_Y;
      default: c = fbm_pkg::OFS_Z;
    endcase
    return SW'((64'(IDX) * c) >> (fbm_pkg::OFS_FRAC - FRAC));
  endfunction

  logic [LAT-1:0]              v_q;
  logic [31:0]                 mag_q [LAT][3];
  logic [2:0]                  neg_q [LAT];
  logic [fbm_pkg::FREQ_W-1:0]  frq_q [LAT];
  logic [fbm_pkg::AMP_W-1:0]   amp_q [LAT-1];
  logic [SUMW-1:0]             sum_q [LAT-1];
  logic [TOTW-1:0]             tot_q [LAT-1];

  logic [63:0]                 fprod;
  logic [fbm_pkg::FREQ_W-1:0]  frq_nx_d;
  logic [56:0]                 ph_d [3], ph_q [3];
  logic [55:0]                 pl_d [3], pl_q [3];
  logic [SW-1:0]               vv_d [3], vv_q [3];
  logic [SW-1:0]               sc_d [3], sc_q [3];
  logic [31:0]                 lat [3];
  logic [15:0]                 tt [3];
  logic [31:0]                 cz3_d [2], cz3_q [2];
  logic [31:0]                 xs3_d [2], xs3_q [2], xs4_q [2], xs5_q [2], xs6_q [2];
  logic [31:0]                 ys3_d [2], ys3_q [2], ys4_q [2];
  logic [15:0]                 t3_d [3], t3_q [3];
  logic [31:0]                 t2_d [3], t2_q [3];
  logic [31:0]                 dz4_d [2], dz4_q [2];
  logic [31:0]                 cube_d [3], cube_q [3];
  logic [19:0]                 poly_d [3], poly_q [3];
  logic [WW-1:0]               w5_d [3], w5_q [3], w6_q [3], w7_q [3], w8_q [3];
  logic [WW-1:0]               wy9_q, wz9_q, wz10_q;
  logic [31:0]                 cy5_d [2][2], cy5_q [2][2];
  logic [31:0]                 dy6_d [2][2], dy6_q [2][2];
  logic [31:0]                 cx7_d [2][2][2], cx7_q [2][2][2];
  logic [31:0]                 dx8_d [2][2][2], dx8_q [2][2][2];
  logic [VW-1:0]               mx9_d [2][2], mx9_q [2][2];
  logic [VW-1:0]               my10_d [2], my10_q [2];
  logic [VW-1:0]               n11_d, n11_q;
  logic [SUMW-1:0]             sum_acc_d, sum_acc_q;
  logic [TOTW-1:0]             tot_acc_d, tot_acc_q;
  logic [fbm_pkg::AMP_W-1:0]   amp_nx_d, amp_nx_q;

  always_comb begin
    fprod    = 64'(freq_i) * 64'(lacun_i);
    frq_nx_d = (fprod[63:12] > 52'(fbm_pkg::FREQ_CAP)) ? fbm_pkg::FREQ_CAP : fprod[60:12];
    for (int a = 0; a < 3; a++) begin
      ph_d[a] = 57'(mag_i[a]) * 57'(freq_i[48:24]);
      pl_d[a] = 56'(mag_i[a]) * 56'(freq_i[23:0]);
    end
  end

  always_comb begin
    logic [68:0] phs;
    logic [56:0] plr;
    for (int a = 0; a < 3; a++) begin
      phs     = {ph_q[a], 12'd0};
      plr     = 57'(pl_q[a]) + (neg_q[0][a] ? 57'd4095 : 57'd0);
      vv_d[a] = phs[SW-1:0] + SW'(plr[56:12]);
      sc_d[a] = neg_q[1][a] ? axis_ofs(a) - vv_q[a] : vv_q[a] + axis_ofs(a);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign lat[a] = sc_q[a][FRAC+31:FRAC];
    if (FRAC >= 16) begin : g_trunc
      assign tt[a] = sc_q[a][FRAC-1:FRAC-16];
    end else begin : g_widen
      assign tt[a] = {sc_q[a][FRAC-1:0], {(16-FRAC){1'b0}}};
    end
  end

  always_comb begin
    logic [47:0] cp;
    logic [36:0] pp;
    logic [51:0] wp;
    for (int j = 0; j < 2; j++) begin
      cz3_d[j] = fbm_pkg::wang_pre(lat[2] + 32'(j));
      xs3_d[j] = lat[0] + 32'(j);
      ys3_d[j] = lat[1] + 32'(j);
      dz4_d[j] = fbm_pkg::wang_mul(cz3_q[j]);
    end
    for (int a = 0; a < 3; a++) begin
      t3_d[a]   = tt[a];
      t2_d[a]   = 32'(tt[a]) * 32'(tt[a]);
      cp        = 48'(t2_q[a]) * 48'(t3_q[a]);
      cube_d[a] = cp[47:16];
      pp        = 37'(t2_q[a]) * 37'd6 + (37'd10 << 32) - ((37'(t3_q[a]) * 37'd15) << 16);
      poly_d[a] = pp[35:16];
      wp        = 52'(cube_q[a]) * 52'(poly_q[a]);
      w5_d[a]   = wp[48:32];
    end
    for (int jy = 0; jy < 2; jy++) begin
      for (int jz = 0; jz < 2; jz++) begin
        cy5_d[jy][jz] = fbm_pkg::wang_pre(ys4_q[jy] ^ fbm_pkg::wang_post(dz4_q[jz]));
        dy6_d[jy][jz] = fbm_pkg::wang_mul(cy5_q[jy][jz]);
        for (int jx = 0; jx < 2; jx++) begin
          cx7_d[jx][jy][jz] = fbm_pkg::wang_pre(xs6_q[jx] ^
                                                fbm_pkg::wang_post(dy6_q[jy][jz]));
          dx8_d[jx][jy][jz] = fbm_pkg::wang_mul(cx7_q[jx][jy][jz]);
        end
      end
    end
  end

  always_comb begin
    logic [31:0] c0;
    logic [31:0] c1;
    for (int jy = 0; jy < 2; jy++) begin
      for (int jz = 0; jz < 2; jz++) begin
        c0 = fbm_pkg::wang_post(dx8_q[0][jy][jz]);
        c1 = fbm_pkg::wang_post(dx8_q[1][jy][jz]);
        mx9_d[jy][jz] = fbm_pkg::value_mix(c0[31:9], c1[31:9], w8_q[0]);
      end
    end
    for (int jz = 0; jz < 2; jz++) begin
      my10_d[jz] = fbm_pkg::value_mix(mx9_q[0][jz], mx9_q[1][jz], wy9_q);
    end
    n11_d = fbm_pkg::value_mix(my10_q[0], my10_q[1], wz10_q);
  end

  always_comb begin
    logic [39:0] np;
    logic [32:0] ap;
    np        = 40'(n11_q) * 40'(amp_q[LAT-2]);
    ap        = 33'(amp_q[LAT-2]) * 33'(gain_i);
    sum_acc_d = sum_q[LAT-2] + (active_i ? SUMW'(np) : '0);
    tot_acc_d = tot_q[LAT-2] + (active_i ? TOTW'(amp_q[LAT-2]) : '0);
    amp_nx_d  = ap[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0] <= mag_i;
      neg_q[0] <= neg_i;
      frq_q[0] <= frq_nx_d;
      amp_q[0] <= amp_i;
      sum_q[0] <= sum_i;
      tot_q[0] <= tot_i;
      for (int k = 1; k < LAT; k++) begin
        mag_q[k] <= mag_q[k-1];
        neg_q[k] <= neg_q[k-1];
        frq_q[k] <= frq_q[k-1];
      end
      for (int k = 1; k < LAT - 1; k++) begin
        amp_q[k] <= amp_q[k-1];
        sum_q[k] <= sum_q[k-1];
        tot_q[k] <= tot_q[k-1];
      end
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      vv_q   <= vv_d;
      sc_q   <= sc_d;
      cz3_q  <= cz3_d;
      xs3_q  <= xs3_d;
      xs4_q  <= xs3_q;
      xs5_q  <= xs4_q;
      xs6_q  <= xs5_q;
      ys3_q  <= ys3_d;
      ys4_q  <= ys3_q;
      t3_q   <= t3_d;
      t2_q   <= t2_d;
      dz4_q  <= dz4_d;
      cube_q <= cube_d;
      poly_q <= poly_d;
      w5_q   <= w5_d;
      w6_q   <= w5_q;
      w7_q   <= w6_q;
      w8_q   <= w7_q;
      wy9_q  <= w8_q[1];
      wz9_q  <= w8_q[2];
      wz10_q <= wz9_q;
      cy5_q  <= cy5_d;
      dy6_q  <= dy6_d;
      cx7_q  <= cx7_d;
      dx8_q  <= dx8_d;
      mx9_q  <= mx9_d;
      my10_q <= my10_d;
      n11_q  <= n11_d;
      sum_acc_q <= sum_acc_d;
      tot_acc_q <= tot_acc_d;
      amp_nx_q  <= amp_nx_d;
    end
  end

  assign valid_o = v_q[LAT-1];
  assign mag_o   = mag_q[LAT-1];
  assign neg_o   = neg_q[LAT-1];
  assign freq_o  = frq_q[LAT-1];
  assign amp_o   = amp_nx_q;
  assign sum_o   = sum_acc_q;
  assign tot_o   = tot_acc_q;

endmodule

FILE: src/fbm_div_stage.sv
// One restoring step of the normalizing divider: resolves one quotient bit.
// Depends on fbm_pkg.
module fbm_div_stage #(
  parameter int SUMW = 43,
  parameter int TOTW = 20,
  parameter int K    = 22
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [SUMW-1:0]            rem_i,
  input  logic [TOTW-1:0]            tot_i,
  input  logic [fbm_pkg::VAL_W-1:0]  quo_i,
  output logic                       valid_o,
  output logic [SUMW-1:0]            rem_o,
  output logic [TOTW-1:0]            tot_o,
  output logic [fbm_pkg::VAL_W-1:0]  quo_o
);

  logic                       valid_q;
  logic [SUMW-1:0]            dsh;
  logic                       fits;
  logic [SUMW-1:0]            rem_d, rem_q;
  logic [fbm_pkg::VAL_W-1:0]  quo_d, quo_q;
  logic [TOTW-1:0]            tot_q;

  always_comb begin
    dsh   = SUMW'(tot_i) << K;
    fits  = rem_i >= dsh;
    rem_d = fits ? rem_i - dsh : rem_i;
    quo_d = quo_i;
    quo_d[K] = fits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      tot_q <= tot_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign tot_o   = tot_q;
  assign quo_o   = quo_q;

endmodule

FILE: src/fbm_value_noise_3d_unit.sv
// Top level of the fractal value noise unit: configuration registers, entry
// stage, chain of octave cells, normalizing divider and output register.
// Depends on fbm_pkg, fbm_octave_cell and fbm_div_stage.
//
// The unit takes one point per clock and returns one noise sample per clock while it is not stalled.
// Every octave has its own 13-stage cell and the division by the total
// amplitude is a 23-stage restoring chain; an item passes through all
// MAX_OCTAVES cells and the whole divider, whatever the octave count.
// The pipeline moves as a whole; it stops only while the output register and
// the last divider stage both hold items and the output is stalled.
module fbm_value_noise_3d_unit #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fbm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [31:0]              coord_x_i,
  input  logic signed [31:0]              coord_y_i,
  input  logic signed [31:0]              coord_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [15:0]              noise_value_o
);

  localparam int OCTW = $clog2(MAX_OCTAVES + 1);
  localparam int TOTW = 16 + OCTW;
  localparam int SUMW = fbm_pkg::VAL_W + TOTW;
  localparam int DIVN = fbm_pkg::VAL_W;

  logic [3:0]  octaves_q;
  logic [15:0] gain_q;
  logic [14:0] lacun_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q <= fbm_pkg::OCTAVES_RST;
      gain_q    <= fbm_pkg::GAIN_RST;
      lacun_q   <= fbm_pkg::LACUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbm_pkg::REG_OCTAVES: octaves_q <= cfg_data_i[3:0];
        fbm_pkg::REG_GAIN:    gain_q    <= cfg_data_i;
        fbm_pkg::REG_LACUN:   lacun_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic [4:0]             neff;
  logic [MAX_OCTAVES-1:0] act;

  always_comb begin
    if (octaves_q == 4'd0) begin
      neff = 5'd1;
    end else if ({1'b0, octaves_q} > 5'(MAX_OCTAVES)) begin
      neff = 5'(MAX_OCTAVES);
    end else begin
      neff = {1'b0, octaves_q};
    end
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      act[i] = i < int'(neff);
    end
  end

  logic                         en;
  logic                         ent_v_q;
  logic [31:0]                  ent_mag_q [3];
  logic [2:0]                   ent_neg_q;
  logic [31:0]                  raw [3];

  logic                         c_v   [MAX_OCTAVES+1];
  logic [31:0]                  c_mag [MAX_OCTAVES+1][3];
  logic [2:0]                   c_neg [MAX_OCTAVES+1];
  logic [fbm_pkg::FREQ_W-1:0]   c_frq [MAX_OCTAVES+1];
  logic [fbm_pkg::AMP_W-1:0]    c_amp [MAX_OCTAVES+1];
  logic [SUMW-1:0]              c_sum [MAX_OCTAVES+1];
  logic [TOTW-1:0]              c_tot [MAX_OCTAVES+1];

  logic                         d_v   [DIVN+1];
  logic [SUMW-1:0]              d_rem [DIVN+1];
  logic [TOTW-1:0]              d_tot [DIVN+1];
  logic [fbm_pkg::VAL_W-1:0]    d_quo [DIVN+1];

  logic                         out_valid_q;
  logic [15:0]                  noise_q;

  assign en         = !(d_v[DIVN] && out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign raw[0] = coord_x_i;
  assign raw[1] = coord_y_i;
  assign raw[2] = coord_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else if (en) begin
      ent_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ent_neg_q[a] <= raw[a][31];
        ent_mag_q[a] <= raw[a][31] ? 32'd0 - raw[a] : raw[a];
      end
    end
  end

  assign c_v[0]   = ent_v_q;
  assign c_mag[0] = ent_mag_q;
  assign c_neg[0] = ent_neg_q;
  assign c_frq[0] = fbm_pkg::FREQ_ONE;
  assign c_amp[0] = fbm_pkg::AMP_ONE;
  assign c_sum[0] = '0;
  assign c_tot[0] = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fbm_octave_cell #(
      .IDX  (i),
      .FRAC (COORD_FRAC_BITS),
      .SUMW (SUMW),
      .TOTW (TOTW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (act[i]),
      .gain_i   (gain_q),
      .lacun_i  (lacun_q),
      .valid_i  (c_v[i]),
      .mag_i    (c_mag[i]),
      .neg_i    (c_neg[i]),
      .freq_i   (c_frq[i]),
      .amp_i    (c_amp[i]),
      .sum_i    (c_sum[i]),
      .tot_i    (c_tot[i]),
      .valid_o  (c_v[i+1]),
      .mag_o    (c_mag[i+1]),
      .neg_o    (c_neg[i+1]),
      .freq_o   (c_frq[i+1]),
      .amp_o    (c_amp[i+1]),
      .sum_o    (c_sum[i+1]),
      .tot_o    (c_tot[i+1])
    );
  end

  assign d_v[0]   = c_v[MAX_OCTAVES];
  assign d_rem[0] = c_sum[MAX_OCTAVES];
  assign d_tot[0] = c_tot[MAX_OCTAVES];
  assign d_quo[0] = '0;

  for (genvar j = 0; j < DIVN; j++) begin : g_div
    fbm_div_stage #(
      .SUMW (SUMW),
      .TOTW (TOTW),
      .K    (DIVN - 1 - j)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d_v[j]),
      .rem_i   (d_rem[j]),
      .tot_i   (d_tot[j]),
      .quo_i   (d_quo[j]),
      .valid_o (d_v[j+1]),
      .rem_o   (d_rem[j+1]),
      .tot_o   (d_tot[j+1]),
      .quo_o   (d_quo[j+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!(out_valid_q && out_stall_i)) begin
      out_valid_q <= d_v[DIVN];
    end
  end

  // The quotient stays below 2^23, so the offset result never needs saturation.
  always_ff @(posedge clk_i) begin
    if (!(out_valid_q && out_stall_i)) begin
      noise_q <= {~d_quo[DIVN][22], d_quo[DIVN][21:7]};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    act[0] && ((act & (act + 1'b1)) == '0))
    else $error("octave enables are not a contiguous run from the first octave");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v[0] |-> d_tot[0] >= TOTW'(fbm_pkg::AMP_ONE))
    else $error("total amplitude below the first octave weight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v[DIVN] |-> d_rem[DIVN] < SUMW'(d_tot[DIVN]))
    else $error("divider remainder not below the divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !d_v[DIVN] |=> !out_valid_o)
    else $error("output item repeated after it was taken");

endmodule

FILE: sim/fbm_value_noise_3d_unit_tb.sv
// Testbench for fbm_value_noise_3d_unit: drives points, predicts each noise sample
// with a local fixed-point fractal noise computation and checks results in order.
// Depends on fbm_pkg and the RTL of the unit.
module fbm_value_noise_3d_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OCT_MAX = 8;
  localparam int FRAC = 16;
  localparam logic [fbm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fbm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [fbm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] noise_value_o;

  logic [3:0] octaves_q = fbm_pkg::OCTAVES_RST;
  logic [15:0] gain_q = fbm_pkg::GAIN_RST;
  logic [14:0] lacun_q = fbm_pkg::LACUN_RST;
  logic signed [15:0] noise_expected[$];
  int errors = 0;
  int idle_pct = 16;
  int hold_cycles = 0;

  fbm_value_noise_3d_unit u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("fbm_value_noise_3d_unit_tb: errors");
    $finish;
  end

  function automatic logic [31:0] hash32(logic [31:0] v);
    v = (v ^ 32'd61) ^ (v >> 16);
    v = v * 32'd9;
    v = v ^ (v >> 4);
    v = v * 32'h27d4eb2d;
    return v ^ (v >> 15);
  endfunction

  function automatic logic [22:0] lattice_value(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z);
    logic [31:0] h;
    h = hash32(x ^ hash32(y ^ hash32(z)));
    return h[31:9];
  endfunction

  function automatic logic [31:0] fade(logic [15:0] t);
    logic [63:0] tt, cube, poly, p;
    tt = 64'(t);
    cube = (tt * tt * tt) >> 16;
    poly = (64'd6 * tt * tt + (64'd10 << 32) - ((64'd15 * tt) << 16)) >> 16;
    p = (cube * poly) >> 32;
    return p[31:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] w);
    logic [63:0] s;
    s = 64'(a) * 64'(32'd65536 - w) + 64'(b) * 64'(w);
    return s[47:16];
  endfunction

  function automatic logic [63:0] scale_coord(logic [31:0] raw, logic [63:0] freq);
    logic [63:0] m, fh, fl, v;
    m = raw[31] ? 64'(32'(0 - raw)) : 64'(raw);
    fh = freq >> 24;
    fl = freq & 64'hFFFFFF;
    if (raw[31]) begin
      v = ((m * fh) << 12) + ((m * fl + 64'd4095) >> 12);
      return 64'd0 - v;
    end
    return ((m * fh) << 12) + ((m * fl) >> 12);
  endfunction

  function automatic logic [31:0] octave_noise(logic [63:0] sx, logic [63:0] sy,
                                               logic [63:0] sz);
    logic [31:0] x, y, z, x1, y1, z1, wx, wy, wz, b0, b1;
    x = sx[47:16]; y = sy[47:16]; z = sz[47:16];
    wx = fade(sx[15:0]); wy = fade(sy[15:0]); wz = fade(sz[15:0]);
    x1 = x + 1; y1 = y + 1; z1 = z + 1;
    b0 = blend(blend(lattice_value(x, y, z), lattice_value(x1, y, z), wx),
               blend(lattice_value(x, y1, z), lattice_value(x1, y1, z), wx), wy);
    b1 = blend(blend(lattice_value(x, y, z1), lattice_value(x1, y, z1), wx),
               blend(lattice_value(x, y1, z1), lattice_value(x1, y1, z1), wx), wy);
    return blend(b0, b1, wz);
  endfunction

  function automatic logic signed [15:0] predict_noise(logic [31:0] cx, logic [31:0] cy,
                                                       logic [31:0] cz);
    logic [63:0] amp, freq, sum, total, q, sx, sy, sz;
    int n, r;
    amp = 64'd65536; freq = 64'd4096; sum = 0; total = 0;
    n = octaves_q;
    if (n == 0) n = 1;
    if (n > OCT_MAX) n = OCT_MAX;
    for (int i = 0; i < n; i++) begin
      sx = scale_coord(cx, freq) +
           ((64'(i) * fbm_pkg::OFS_X) >> (fbm_pkg::OFS_FRAC - FRAC));
      sy = scale_coord(cy, freq) +
           ((64'(i) * fbm_pkg::OFS_Y) >> (fbm_pkg::OFS_FRAC - FRAC));
      sz = scale_coord(cz, freq) +
           ((64'(i) * fbm_pkg::OFS_Z) >> (fbm_pkg::OFS_FRAC - FRAC));
      sum += 64'(octave_noise(sx, sy, sz)) * amp;
      total += amp;
      amp = (amp * gain_q) >> 16;
      freq = (freq * lacun_q) >> 12;
      if (freq > 64'(fbm_pkg::FREQ_CAP)) freq = 64'(fbm_pkg::FREQ_CAP);
    end
    q = sum / total;
    r = int'(q >> 7) - 32768;
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_expected.size() == 0) begin
        $error("unexpected item: noise_value actual %0d", noise_value_o);
        errors++;
      end else begin
        logic signed [15:0] exp_v;
        exp_v = noise_expected.pop_front();
        if (exp_v !== noise_value_o) begin
          $error("noise_value expected %0d actual %0d", exp_v, noise_value_o);
          errors++;
        end
      end
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i <= x; coord_y_i <= y; coord_z_i <= z;
    noise_expected.push_back(predict_noise(x, y, z));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fbm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fbm_pkg::REG_OCTAVES: octaves_q = val[3:0];
      fbm_pkg::REG_GAIN: gain_q = val;
      fbm_pkg::REG_LACUN: lacun_q = val[14:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic test_directed;
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'hFFFFFFFF, 32'h00000001, 32'h0000FFFF);
    send_point(32'h00010000, 32'hFFFF0000, 32'h00008000);
    send_point(32'h7FFF0000, 32'h8000FFFF, 32'h12345678);
    drain();
  endtask

  task automatic test_config_sweep;
    logic [15:0] oct_set[6] = '{16'd1, 16'd8, 16'd0, 16'd15, 16'd9, 16'd3};
    logic [15:0] gain_set[6] = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd40000, 16'd20000};
    logic [15:0] lac_set[6] = '{16'd4096, 16'd16384, 16'd32767, 16'd0, 16'd8192, 16'd10000};
    for (int p = 0; p < 6; p++) begin
      write_reg(fbm_pkg::REG_OCTAVES, oct_set[p]);
      write_reg(fbm_pkg::REG_GAIN, gain_set[p]);
      write_reg(fbm_pkg::REG_LACUN, lac_set[p]);
      write_reg(REG_UNUSED, 16'hFFFF);
      send_point(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      for (int k = 0; k < 60; k++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  task automatic test_random;
    write_reg(fbm_pkg::REG_OCTAVES, 16'($urandom_range(1, 8)));
    write_reg(fbm_pkg::REG_GAIN, 16'($urandom));
    write_reg(fbm_pkg::REG_LACUN, 16'($urandom_range(4096, 16384)));
    for (int k = 0; k < 500; k++) begin
      idle_pct = (k >= 200 && k < 300) ? 0 : 16;
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    idle_pct = 16;
    drain();
  endtask

  task automatic test_backpressure;
    hold_cycles = 400;
    for (int k = 0; k < 200; k++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    if (errors == 0 && noise_expected.size() == 0) begin
      $display("fbm_value_noise_3d_unit_tb: clean");
    end else begin
      $display("fbm_value_noise_3d_unit_tb: errors");
    end
    $finish;
  end
endmodule
